// File: design/tomq_pkg.sv
// Shared types and codes for the timestamp-ordered message queue.
`default_nettype none

package tomq_pkg;

  localparam int TIME_W  = 32;
  localparam int TOPIC_W = 2;
  localparam int MASK_W  = 4;
  localparam int STAT_W  = 3;

  // command codes
  localparam logic CMD_ADD     = 1'b0;
  localparam logic CMD_PROCESS = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_DELIVERED = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNREG     = 3'd4;

  // register index (word address bit) of the topic enable mask
  localparam logic REG_TOPIC_MASK = 1'b0;

  // one stored message
  typedef struct packed {
    logic               valid;
    logic [TIME_W-1:0]  stamp;
    logic [TOPIC_W-1:0] topic;
  } entry_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic add;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/timestamp_ordered_message_queue_top.sv
// Top level of the timestamp-ordered message queue: cell chain, register and result stage.
//
//  port group      | dir  | handshake            | payload
//  ----------------+------+----------------------+------------------------------
//  request in      | in   | in_valid / in_ready  | command, msg_time, msg_topic
//  result out      | out  | out_valid / out_ready| status, out_time, out_topic
//  register bus    | in   | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
// Every cell compares its timestamp with the incoming one and shifts or loads
// at the same edge, so a new request is taken every cycle while in_ready is
// high. The result appears in an output register in the cycle after acceptance.
// in_ready is high while that register is empty or being taken, so a stall on
// the result side holds off only the next request. Reset (rst, synchronous)
// empties the queue and clears the topic mask; it needs no clearing pass.
`default_nettype none

module timestamp_ordered_message_queue_top import tomq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_TOPICS  = 4
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [TIME_W-1:0]  msg_time,
  input  logic [TOPIC_W-1:0] msg_topic,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [TIME_W-1:0]  out_time,
  output logic [TOPIC_W-1:0] out_topic,
  // register bus
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  entry_t                 ents [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] gts;
  logic [QUEUE_DEPTH-1:0] vld;
  cell_ctl_t              ctl;
  logic [MASK_W-1:0]      topic_mask;
  logic                   in_fire;
  logic                   full;
  logic                   head_en;

  // register bus
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TOPIC_MASK) ? {{(32-MASK_W){1'b0}}, topic_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_mask <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TOPIC_MASK) begin
      topic_mask <= pwdata[MASK_W-1:0];
    end
  end

  // queue state seen from the ends of the chain
  assign full    = ents[QUEUE_DEPTH-1].valid;
  assign head_en = ents[0].valid
                   && (32'(ents[0].topic) < 32'(NUM_TOPICS))
                   && topic_mask[ents[0].topic];

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign ctl.add = in_fire && (command == CMD_ADD) && !full;
  assign ctl.pop = in_fire && (command == CMD_PROCESS) && head_en;

  // chain of cells, head at index 0
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_gt;

    if (i == 0) begin : g_head
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_ent = ents[i-1];
      assign left_gt  = gts[i-1];
    end

    if (i == QUEUE_DEPTH-1) begin : g_tail
      assign right_ent = '0;
    end else begin : g_body
      assign right_ent = ents[i+1];
    end

    tomq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .new_time  (msg_time),
      .new_topic (msg_topic),
      .left      (left_ent),
      .left_gt   (left_gt),
      .right     (right_ent),
      .ent       (ents[i]),
      .gt        (gts[i])
    );

    assign vld[i] = ents[i].valid;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_time  <= '0;
      out_topic <= '0;
      if (command == CMD_ADD) begin
        status <= full ? ST_FULL : ST_ACCEPTED;
      end else if (!ents[0].valid) begin
        status <= ST_EMPTY;
      end else if (!head_en) begin
        status    <= ST_UNREG;
        out_topic <= ents[0].topic;
      end else begin
        status    <= ST_DELIVERED;
        out_time  <= ents[0].stamp;
        out_topic <= ents[0].topic;
      end
    end
  end

  // occupied cells form a prefix of the chain
  assert property (@(posedge clk) disable iff (rst) ((vld >> 1) & ~vld) == '0)
    else $error("queue has a hole");

  // an accepted add grows the queue by one
  assert property (@(posedge clk) disable iff (rst) ctl.add |=>
                   $countones(vld) == $past($countones(vld)) + 1)
    else $error("add did not grow queue");

  // a delivery shrinks the queue by one
  assert property (@(posedge clk) disable iff (rst) ctl.pop |=>
                   $countones(vld) == $past($countones(vld)) - 1)
    else $error("delivery did not shrink queue");

  // stored timestamps stay in order
  for (genvar k = 1; k < QUEUE_DEPTH; k++) begin : g_order
    assert property (@(posedge clk) disable iff (rst)
                     ents[k].valid |-> ents[k-1].stamp <= ents[k].stamp)
      else $error("queue out of order");
  end

endmodule

`default_nettype wire

// File: design/tomq_cell.sv
// One slot of the sorted queue: holds a message, shifts, inserts or keeps.
`default_nettype none

module tomq_cell import tomq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctl_t           ctl,
  input  logic [TIME_W-1:0]   new_time,
  input  logic [TOPIC_W-1:0]  new_topic,
  input  entry_t              left,
  input  logic                left_gt,
  input  entry_t              right,
  output entry_t              ent,
  output logic                gt
);

  logic               vld;
  logic [TIME_W-1:0]  stamp;
  logic [TOPIC_W-1:0] topic;

  assign ent = '{valid: vld, stamp: stamp, topic: topic};

  // empty slots count as later than any new message
  assign gt = !vld || (stamp > new_time);

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (ctl.add && gt) begin
      vld <= left_gt ? left.valid : 1'b1;
    end else if (ctl.pop) begin
      vld <= right.valid;
    end
  end

  // payload: shift right behind the insert point, take the new item at it
  always_ff @(posedge clk) begin
    if (ctl.add && gt) begin
      if (left_gt) begin
        stamp <= left.stamp;
        topic <= left.topic;
      end else begin
        stamp <= new_time;
        topic <= new_topic;
      end
    end else if (ctl.pop) begin
      stamp <= right.stamp;
      topic <= right.topic;
    end
  end

endmodule

`default_nettype wire
